[sv/cim_pkg.sv]
`timescale 1ns / 1ps
// Package for the coverage interval merger: field widths, register indexes,
// the queue entry type and the operation codes. No dependencies.
package cim_pkg;

	// Field widths.
	localparam int SEQ_W    = 16;
	localparam int COORD_W  = 31;
	localparam int FIN_W    = 32;
	localparam int PLOIDY_W = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DEPTH_THRESHOLD = 2'd0;
	localparam cfg_idx_t REG_MERGE_ENABLE    = 2'd1;
	localparam cfg_idx_t REG_GAP_DISTANCE    = 2'd2;

	localparam logic [COORD_W-1:0] DEPTH_RESET = 31'd10;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// What the back does with a queued transaction.
	typedef enum logic [1:0] {
		OP_PASS,
		OP_MERGE,
		OP_FLUSH
	} cim_op_t;

	typedef struct packed {
		cim_op_t                op;
		logic [SEQ_W-1:0]       seq;
		logic [COORD_W-1:0]     pos;
		logic [FIN_W-1:0]       fin;
		logic [PLOIDY_W-1:0]    ploidy;
	} cim_entry_t;

	// Queue handshake seen from the back.
	typedef struct packed {
		logic       valid;
		cim_entry_t head;
	} cim_qhead_t;

endpackage

[sv/cim_rec_if.sv]
`timescale 1ns / 1ps
// Input stream interface: one genomic record or flush command per transaction.
// Uses cim_pkg for the field widths.
interface cim_rec_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [cim_pkg::SEQ_W-1:0]       sequence_id;
	logic [cim_pkg::COORD_W-1:0]     position;
	logic [cim_pkg::COORD_W-1:0]     span_length;
	logic [cim_pkg::COORD_W-1:0]     read_depth;
	logic [cim_pkg::PLOIDY_W-1:0]    ploidy;

	modport source (
		output valid, command, sequence_id, position, span_length, read_depth, ploidy,
		input  ready
	);
	modport sink (
		input  valid, command, sequence_id, position, span_length, read_depth, ploidy,
		output ready
	);
endinterface

[sv/cim_ivl_if.sv]
`timescale 1ns / 1ps
// Output stream interface: one emitted interval per transaction.
// Uses cim_pkg for the field widths.
interface cim_ivl_if;
	logic                            valid;
	logic                            ready;
	logic [cim_pkg::SEQ_W-1:0]       out_sequence_id;
	logic [cim_pkg::COORD_W-1:0]     out_start;
	logic [cim_pkg::FIN_W-1:0]       out_end;
	logic [cim_pkg::PLOIDY_W-1:0]    out_ploidy;

	modport source (
		output valid, out_sequence_id, out_start, out_end, out_ploidy,
		input  ready
	);
	modport sink (
		input  valid, out_sequence_id, out_start, out_end, out_ploidy,
		output ready
	);
endinterface

[sv/cim_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input transactions, drops shallow records, computes the
// record end and classifies each kept transaction. Depends on cim_pkg, cim_rec_if.
module cim_front (
	cim_rec_if.sink                     rec,
	input  logic [cim_pkg::COORD_W-1:0] depth_threshold,
	input  logic                        merge_enable,
	input  logic                        q_full,
	output logic                        push,
	output cim_pkg::cim_entry_t         push_entry
);
	import cim_pkg::*;

	logic keep;

	// Accept whenever the queue has room; flushes are always kept.
	assign rec.ready = !q_full;
	assign keep      = rec.command || (rec.read_depth >= depth_threshold);
	assign push      = rec.valid && rec.ready && keep;

	// Classify and build the queue entry.
	always_comb begin
		push_entry.seq    = rec.sequence_id;
		push_entry.pos    = rec.position;
		push_entry.fin    = {1'b0, rec.position} + {1'b0, rec.span_length};
		push_entry.ploidy = rec.ploidy;
		if (rec.command) begin
			push_entry.op = OP_FLUSH;
		end else if (merge_enable) begin
			push_entry.op = OP_MERGE;
		end else begin
			push_entry.op = OP_PASS;
		end
	end

endmodule

[sv/cim_queue.sv]
`timescale 1ns / 1ps
// Short FIFO that decouples the classifying front from the window back end.
// Depends on cim_pkg.
module cim_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cim_pkg::cim_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output cim_pkg::cim_qhead_t qhead
);
	import cim_pkg::*;

	cim_entry_t           entries_q [QDEPTH];
	logic [QAW-1:0]       wr_ptr_q;
	logic [QAW-1:0]       rd_ptr_q;
	logic [QCW-1:0]       count_q;

	assign full        = (count_q == QCW'(QDEPTH));
	assign qhead.valid = (count_q != '0);
	assign qhead.head  = entries_q[rd_ptr_q];

	// Entry storage, no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qhead.valid)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue fill count out of range");
`endif

endmodule

[sv/cim_back.sv]
`timescale 1ns / 1ps
// Back end: holds the open window, merges or emits per queued transaction and
// drives the registered output stream. Depends on cim_pkg, cim_ivl_if.
module cim_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cim_pkg::cim_qhead_t         qhead,
	input  logic [cim_pkg::COORD_W-1:0] gap_distance,
	output logic                        pop,
	cim_ivl_if.source                   ivl
);
	import cim_pkg::*;

	// Window state.
	logic                  win_open_q;
	logic [COORD_W-1:0]    win_begin_q;
	logic [FIN_W-1:0]      win_fin_q;
	logic [SEQ_W-1:0]      win_seq_q;
	logic [PLOIDY_W-1:0]   win_ploidy_q;

	// Output register.
	logic                  out_valid_q;
	logic [SEQ_W-1:0]      out_seq_q;
	logic [COORD_W-1:0]    out_start_q;
	logic [FIN_W-1:0]      out_end_q;
	logic [PLOIDY_W-1:0]   out_ploidy_q;

	logic                  out_free;
	logic                  too_far;
	logic                  breaks;
	logic                  emit;
	logic                  emit_window;
	logic                  win_load;
	logic                  win_grow;
	logic                  win_close;
	cim_entry_t            e;

	assign e        = qhead.head;
	assign out_free = !out_valid_q || ivl.ready;
	assign pop      = qhead.valid && out_free;

	// Gap test on a 33-bit sum so it cannot wrap.
	assign too_far = ({1'b0, win_fin_q} + {2'b0, gap_distance}) < {2'b0, e.pos};
	assign breaks  = (win_seq_q != e.seq) || (win_ploidy_q != e.ploidy) || too_far;

	// Decide what the popped transaction does.
	always_comb begin
		emit        = 1'b0;
		emit_window = 1'b0;
		win_load    = 1'b0;
		win_grow    = 1'b0;
		win_close   = 1'b0;
		if (pop) begin
			unique case (e.op)
				OP_FLUSH: begin
					emit        = win_open_q;
					emit_window = 1'b1;
					win_close   = 1'b1;
				end
				OP_PASS: begin
					emit = 1'b1;
				end
				OP_MERGE: begin
					if (!win_open_q) begin
						win_load = 1'b1;
					end else if (breaks) begin
						emit        = 1'b1;
						emit_window = 1'b1;
						win_load    = 1'b1;
					end else begin
						win_grow = 1'b1;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// Window open flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_open_q <= 1'b0;
		end else if (win_close) begin
			win_open_q <= 1'b0;
		end else if (win_load) begin
			win_open_q <= 1'b1;
		end
	end

	// Window contents.
	always_ff @(posedge clk) begin
		if (win_load) begin
			win_begin_q  <= e.pos;
			win_fin_q    <= e.fin;
			win_seq_q    <= e.seq;
			win_ploidy_q <= e.ploidy;
		end else if (win_grow) begin
			if (e.pos < win_begin_q) begin
				win_begin_q <= e.pos;
			end
			if (e.fin > win_fin_q) begin
				win_fin_q <= e.fin;
			end
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (ivl.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (emit_window) begin
				out_seq_q    <= win_seq_q;
				out_start_q  <= win_begin_q;
				out_end_q    <= win_fin_q;
				out_ploidy_q <= win_ploidy_q;
			end else begin
				out_seq_q    <= e.seq;
				out_start_q  <= e.pos;
				out_end_q    <= e.fin;
				out_ploidy_q <= e.ploidy;
			end
		end
	end

	assign ivl.valid           = out_valid_q;
	assign ivl.out_sequence_id = out_seq_q;
	assign ivl.out_start       = out_start_q;
	assign ivl.out_end         = out_end_q;
	assign ivl.out_ploidy      = out_ploidy_q;

`ifndef SYNTHESIS
	a_flush_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e.op == OP_FLUSH) |=> !win_open_q)
		else $error("window still open after flush");
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		win_open_q |-> ({1'b0, win_begin_q} <= win_fin_q))
		else $error("open window ends before it starts");
	a_pass_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e.op == OP_PASS) |=> out_valid_q)
		else $error("pass-through transaction produced no result");
	a_merge_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e.op == OP_MERGE) |=> win_open_q)
		else $error("merge transaction left no open window");
`endif

endmodule

[sv/coverage_interval_merger.sv]
`timescale 1ns / 1ps
// Top level of the coverage interval merger: configuration registers and the
// front, queue and back. Depends on cim_pkg, cim_rec_if, cim_ivl_if and submodules.
//
//   channel  direction  content
//   rec      in         record or flush command (valid/ready)
//   ivl      out        emitted interval (valid/ready)
//   cfg_*    in         register write: cfg_write, cfg_index, cfg_data
//
// One transaction per cycle is taken while the queue has room, and at most one
// result per cycle is delivered while ivl.ready is high. An accepted transaction
// waits in the queue; at its head, with the output free, it is compared with the
// window and the output register loaded. Reset clears the queue, the window and
// the output valid, and loads the register reset values. A stalled output holds
// its interval; the queue takes up to four transactions before rec.ready falls.
module coverage_interval_merger (
	input  logic                           clk,
	input  logic                           arst_n,
	cim_rec_if.sink                        rec,
	cim_ivl_if.source                      ivl,
	input  logic                           cfg_write,
	input  logic [cim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cim_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cim_pkg::*;

	logic [COORD_W-1:0] depth_threshold_q;
	logic               merge_enable_q;
	logic [COORD_W-1:0] gap_distance_q;

	logic               push;
	cim_entry_t         push_entry;
	logic               pop;
	logic               q_full;
	cim_qhead_t         qhead;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_threshold_q <= DEPTH_RESET;
			merge_enable_q    <= 1'b1;
			gap_distance_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEPTH_THRESHOLD: depth_threshold_q <= cfg_data[COORD_W-1:0];
				REG_MERGE_ENABLE:    merge_enable_q    <= cfg_data[0];
				REG_GAP_DISTANCE:    gap_distance_q    <= cfg_data[COORD_W-1:0];
				default: begin
					merge_enable_q <= merge_enable_q;
				end
			endcase
		end
	end

	cim_front u_front (
		.rec             (rec),
		.depth_threshold (depth_threshold_q),
		.merge_enable    (merge_enable_q),
		.q_full          (q_full),
		.push            (push),
		.push_entry      (push_entry)
	);

	cim_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.qhead      (qhead)
	);

	cim_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qhead        (qhead),
		.gap_distance (gap_distance_q),
		.pop          (pop),
		.ivl          (ivl)
	);

endmodule
